// ===== rtl/core/scs_pkg.sv =====
// Shared types and constants for the horizontal seam finder.
`default_nettype none
package scs_pkg;
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 6;
	localparam int DIM_W      = 7;
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_W      = 24;
	localparam int COST_W     = 25;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// datapath operation selected by the controller
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_EN    = 3'd2,
		OP_DP    = 3'd3,
		OP_START = 3'd4,
		OP_TRACE = 3'd5
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [2:0]       phase;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0] seam_row;
	} sts_t;

	function automatic logic [ADDR_W-1:0] addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		addr = {r, c};
	endfunction

	function automatic logic [16:0] sqd(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] d;
		d = {8'd0, (a > b) ? a - b : b - a};
		sqd = {1'b0, d * d};
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/scs_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module scs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/scs_datapath.sv =====
// Datapath: pixel and cost memories, energy and path-cost arithmetic.
`default_nettype none
module scs_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire scs_pkg::cmd_t              cmd,
	input  wire logic [scs_pkg::PIX_W-1:0]  pixel,
	input  wire logic [scs_pkg::ROW_W-1:0]  hm1,
	input  wire logic [scs_pkg::COL_W-1:0]  wm1,
	output scs_pkg::sts_t                   sts
);
	import scs_pkg::*;

	logic              pwe;
	logic [ADDR_W-1:0] pwa, pra, cwa, cra;
	logic [PIX_W-1:0]  pwd, prd;
	logic              cwe;
	logic [COST_W-1:0] cwd, crd;

	scs_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix (
		.clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));
	scs_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost (
		.clk(clk), .we(cwe), .waddr(cwa), .wdata(cwd), .raddr(cra), .rdata(crd));

	logic [ROW_W-1:0] ru, rd;
	logic [COL_W-1:0] cl, cr;
	logic [PIX_W-1:0] a_q;
	logic [COST_W-1:0] acc_q, bv_q;
	logic [ROW_W-1:0]  best_q, seam_q;
	logic [COST_W-1:0] pe;
	logic [ROW_W-1:0]  rr;
	logic              has_up, has_dn;

	// current row for traceback is seam_q; for the others cmd.row
	assign rr = (cmd.op == OP_TRACE) ? seam_q : cmd.row;
	assign ru = (cmd.row == '0) ? hm1 : cmd.row - 1'b1;
	assign rd = (cmd.row == hm1) ? '0 : cmd.row + 1'b1;
	assign cl = (cmd.col == '0) ? wm1 : cmd.col - 1'b1;
	assign cr = (cmd.col == wm1) ? '0 : cmd.col + 1'b1;
	assign has_up = rr != '0;
	assign has_dn = rr != hm1;

	assign pe = COST_W'(sqd(a_q[23:16], prd[23:16])) + COST_W'(sqd(a_q[15:8], prd[15:8]))
		+ COST_W'(sqd(a_q[7:0], prd[7:0]));

	assign pwe = cmd.op == OP_LOAD;
	assign pwa = addr(cmd.row, cmd.col);
	assign pwd = pixel;

	// read addresses by phase; memory data returns one phase later
	always_comb begin
		pra = addr(cmd.row, cl);
		cra = addr(cmd.row, cmd.col);
		case (cmd.op)
			OP_EN: begin
				case (cmd.phase)
					3'd0: pra = addr(cmd.row, cl);
					3'd1: pra = addr(cmd.row, cr);
					3'd2: pra = addr(ru, cmd.col);
					default: pra = addr(rd, cmd.col);
				endcase
			end
			OP_DP, OP_TRACE: begin
				case (cmd.phase)
					3'd0: cra = addr(rr, cmd.col + 1'b1);
					3'd1: cra = addr(has_up ? rr - 1'b1 : rr, cmd.col + 1'b1);
					3'd2: cra = addr(has_dn ? rr + 1'b1 : rr, cmd.col + 1'b1);
					default: cra = addr(cmd.row, cmd.col);
				endcase
				if (cmd.op == OP_TRACE) begin
					case (cmd.phase)
						3'd0: cra = addr(rr, cmd.col);
						3'd1: cra = addr(has_up ? rr - 1'b1 : rr, cmd.col);
						3'd2: cra = addr(has_dn ? rr + 1'b1 : rr, cmd.col);
						default: cra = addr(rr, cmd.col);
					endcase
				end
			end
			OP_START: cra = addr(cmd.row, '0);
			default: ;
		endcase
	end

	// writes: energy at phase 4, dp at phase 4
	always_comb begin
		cwe = 1'b0;
		cwa = addr(cmd.row, cmd.col);
		cwd = acc_q;
		if (cmd.op == OP_EN && cmd.phase == 3'd4) begin
			cwe = 1'b1;
			cwd = acc_q + pe;
		end else if (cmd.op == OP_DP && cmd.phase == 3'd4) begin
			cwe = 1'b1;
			cwd = crd + bv_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_EN: begin
				case (cmd.phase)
					3'd1: a_q <= prd;
					3'd2: acc_q <= pe;
					3'd3: a_q <= prd;
					default: ;
				endcase
			end
			OP_DP, OP_TRACE: begin
				case (cmd.phase)
					3'd1: begin
						bv_q <= crd;
						best_q <= rr;
					end
					3'd2: if (has_up && crd < bv_q) begin
						bv_q <= crd;
						best_q <= rr - 1'b1;
					end
					3'd3: if (has_dn && crd < bv_q) begin
						bv_q <= crd;
						best_q <= rr + 1'b1;
					end
					default: ;
				endcase
			end
			// running minimum of column 0, row 0 first
			OP_START: begin
				if (cmd.phase == 3'd1) bv_q <= crd;
				else if (cmd.phase == 3'd2 && crd < bv_q) bv_q <= crd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seam_q <= '0;
		end else if (cmd.op == OP_START) begin
			if (cmd.phase == 3'd0) seam_q <= '0;
			else if (cmd.phase == 3'd2 && crd < bv_q) seam_q <= cmd.row - 1'b1;
		end else if (cmd.op == OP_TRACE && cmd.phase == 3'd4) begin
			seam_q <= best_q;
		end
	end

	assign sts.seam_row = seam_q;
endmodule
`default_nettype wire

// ===== rtl/core/scs_ctrl.sv =====
// Controller: sequences load, energy, path-cost, start search, traceback and output.
`default_nettype none
module scs_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic [0:0]                 cfg_index,
	input  wire logic [scs_pkg::DIM_W-1:0]  cfg_data,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [scs_pkg::COL_W-1:0]       out_col,
	output logic                            out_last,
	output logic [scs_pkg::ROW_W-1:0]       hm1,
	output logic [scs_pkg::COL_W-1:0]       wm1,
	output scs_pkg::cmd_t                   cmd
);
	import scs_pkg::*;

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_EN    = 6'b000010,
		S_DP    = 6'b000100,
		S_START = 6'b001000,
		S_TRACE = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] w_q, h_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [2:0]       ph_q;

	function automatic logic [5:0] eff(input logic [DIM_W-1:0] v);
		if (v < 7'd2) eff = 6'd1;
		else if (v > 7'd64) eff = 6'd63;
		else eff = 6'(v - 1'b1);
	endfunction

	assign wm1 = eff(w_q);
	assign hm1 = eff(h_q);
	assign s_tready = state_q == S_LOAD;
	assign m_tvalid = state_q == S_OUT;
	assign out_col  = col_q;
	assign out_last = col_q == wm1;

	always_comb begin
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.phase = ph_q;
		case (state_q)
			S_LOAD:  cmd.op = (s_tvalid) ? OP_LOAD : OP_NONE;
			S_EN:    cmd.op = OP_EN;
			S_DP:    cmd.op = OP_DP;
			S_START: cmd.op = OP_START;
			S_TRACE: cmd.op = OP_TRACE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			w_q <= 7'd64;
			h_q <= 7'd64;
			row_q <= '0;
			col_q <= '0;
			ph_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (cfg_valid) begin
						if (cfg_index == REG_WIDTH) w_q <= cfg_data;
						else h_q <= cfg_data;
						row_q <= '0;
						col_q <= '0;
					end else if (s_tvalid) begin
						if (col_q != wm1) col_q <= col_q + 1'b1;
						else begin
							col_q <= '0;
							if (row_q != hm1) row_q <= row_q + 1'b1;
							else begin
								row_q <= '0;
								state_q <= S_EN;
								ph_q <= '0;
							end
						end
					end
				end
				S_EN: begin
					if (ph_q != 3'd4) ph_q <= ph_q + 1'b1;
					else begin
						ph_q <= '0;
						if (col_q != wm1) col_q <= col_q + 1'b1;
						else begin
							col_q <= '0;
							if (row_q != hm1) row_q <= row_q + 1'b1;
							else begin
								row_q <= '0;
								col_q <= wm1 - 1'b1;
								state_q <= S_DP;
							end
						end
					end
				end
				S_DP: begin
					if (ph_q != 3'd4) ph_q <= ph_q + 1'b1;
					else begin
						ph_q <= '0;
						if (row_q != hm1) row_q <= row_q + 1'b1;
						else begin
							row_q <= '0;
							if (col_q != '0) col_q <= col_q - 1'b1;
							else state_q <= S_START;
						end
					end
				end
				S_START: begin
					// phase 0 primes, then one row per cycle with read latency
					if (ph_q == 3'd0) begin
						ph_q <= 3'd1;
						row_q <= row_q + 1'b1;
					end else if (ph_q == 3'd1) begin
						ph_q <= 3'd2;
						row_q <= row_q + 1'b1;
					end else if (row_q == hm1 + 6'd1 || (row_q == '0)) begin
						ph_q <= '0;
						row_q <= '0;
						col_q <= '0;
						state_q <= S_OUT;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				S_TRACE: begin
					if (ph_q != 3'd4) ph_q <= ph_q + 1'b1;
					else begin
						ph_q <= '0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						if (col_q == wm1) begin
							col_q <= '0;
							state_q <= S_LOAD;
						end else begin
							col_q <= col_q + 1'b1;
							state_q <= S_TRACE;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/seam_carving_horizontal_seam.sv =====
// Top level of the horizontal seam finder.
// Order of work: pixels load one per accepted transfer; after the last pixel, energy
// for every pixel, path cost for every pixel of all but the last column, the start
// search, then one seam entry per column, each after the first following a traceback.
// Throughput is set by the single read port of each memory; input waits for the seam.
// Reset: asynchronous active low; width and height return to 64, load restarts.
`default_nettype none
module seam_carving_horizontal_seam (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // seam_row[5:0], seam_column[11:6], zero fill
	output logic             m_tlast
);
	import scs_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [ROW_W-1:0] hm1;
	logic [COL_W-1:0] wm1, oc;
	logic             st_rdy;

	// register writes only while loading
	assign cfg_ready = st_rdy;

	scs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid && !cfg_valid), .s_tready(st_rdy),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .out_col(oc), .out_last(m_tlast),
		.hm1(hm1), .wm1(wm1), .cmd(cmd));

	assign s_tready = st_rdy && !cfg_valid;

	scs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.pixel({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
		.hm1(hm1), .wm1(wm1), .sts(sts));

	assign m_tdata = {4'd0, oc, sts.seam_row};
endmodule
`default_nettype wire

// ===== test/seam_checker.sv =====
// Watches the seam finder's channels, predicts each seam and compares the outputs.
module seam_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	input  wire logic        m_tlast,
	output int               fails,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import scs_pkg::*;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} seam_entry_t;

	logic [PIX_W-1:0]  pix_mem [DEPTH];
	logic [COST_W-1:0] cost_mem [DEPTH];
	int unsigned width_reg, height_reg, ld_row, ld_col;
	seam_entry_t seam_q[$];

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
		if (v < 2) return 2;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int unsigned loc(input int unsigned r, input int unsigned c);
		return (r * MAX_WIDTH + c) % DEPTH;
	endfunction

	function automatic int unsigned pair_energy(input logic [23:0] a, input logic [23:0] b);
		int unsigned sum;
		int d;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
			sum += d * d;
		end
		return sum;
	endfunction

	// cheapest of r, r-1, r+1 in column c; ties favor r, then the row above
	function automatic int unsigned best_row(input int unsigned r, input int unsigned c,
		input int unsigned h);
		int unsigned pick;
		logic [COST_W-1:0] bv;
		pick = r;
		bv = cost_mem[loc(r, c)];
		if (r > 0 && cost_mem[loc(r - 1, c)] < bv) begin
			pick = r - 1;
			bv = cost_mem[loc(r - 1, c)];
		end
		if (r + 1 < h && cost_mem[loc(r + 1, c)] < bv)
			pick = r + 1;
		return pick;
	endfunction

	task automatic plan_seam(input int unsigned w, input int unsigned h);
		int unsigned cl, cr, ru, rd, b, row;
		seam_entry_t e;
		for (int unsigned r = 0; r < h; r++)
			for (int unsigned c = 0; c < w; c++) begin
				cl = (c == 0) ? w - 1 : c - 1;
				cr = (c + 1 >= w) ? 0 : c + 1;
				ru = (r == 0) ? h - 1 : r - 1;
				rd = (r + 1 >= h) ? 0 : r + 1;
				cost_mem[loc(r, c)] = COST_W'(pair_energy(pix_mem[loc(r, cl)], pix_mem[loc(r, cr)])
					+ pair_energy(pix_mem[loc(ru, c)], pix_mem[loc(rd, c)]));
			end
		for (int c = int'(w) - 2; c >= 0; c--)
			for (int unsigned r = 0; r < h; r++) begin
				b = best_row(r, c + 1, h);
				cost_mem[loc(r, c)] = cost_mem[loc(r, c)] + cost_mem[loc(b, c + 1)];
			end
		row = 0;
		for (int unsigned r = 1; r < h; r++)
			if (cost_mem[loc(r, 0)] < cost_mem[loc(row, 0)]) row = r;
		for (int unsigned c = 0; c < w; c++) begin
			if (c > 0) row = best_row(row, c, h);
			e.row = ROW_W'(row);
			e.col = COL_W'(c);
			e.last = (c + 1 == w);
			seam_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		seam_entry_t want;
		int unsigned w, h;
		if (!arst_n) begin
			width_reg = 64;
			height_reg = 64;
			ld_row = 0;
			ld_col = 0;
			seam_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (seam_q.size() == 0) begin
					$error("seam entry with nothing expected: row %0d col %0d",
						m_tdata[5:0], m_tdata[11:6]);
					fails++;
				end else begin
					want = seam_q.pop_front();
					if (m_tdata[5:0] !== want.row) begin
						$error("seam_row: expected %0d, got %0d", want.row, m_tdata[5:0]);
						fails++;
					end
					if (m_tdata[11:6] !== want.col) begin
						$error("seam_column: expected %0d, got %0d", want.col, m_tdata[11:6]);
						fails++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
				ld_row = 0;
				ld_col = 0;
			end
			if (s_tvalid && s_tready) begin
				w = clamp_dim(width_reg, MAX_WIDTH);
				h = clamp_dim(height_reg, MAX_HEIGHT);
				if (ld_row >= h || ld_col >= w) begin
					ld_row = 0;
					ld_col = 0;
				end
				pix_mem[loc(ld_row, ld_col)] = s_tdata;
				if (ld_col + 1 < w) begin
					ld_col++;
				end else begin
					ld_col = 0;
					if (ld_row + 1 < h) begin
						ld_row++;
					end else begin
						ld_row = 0;
						plan_seam(w, h);
					end
				end
			end
			pending = seam_q.size();
		end
	end
endmodule

// ===== test/seam_carving_horizontal_seam_tb.sv =====
// Stimulus and verdict for the horizontal seam finder.
module seam_carving_horizontal_seam_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [6:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	int          fails;
	int          pending;
	bit          idle_on;
	bit          hold_req;
	int          pixels_sent;

	seam_carving_horizontal_seam dut (.*);
	seam_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("seam_carving_horizontal_seam_tb failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int held;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 0;
				for (held = 1; held < 2000; held++) @(negedge clk);
				hold_req = 0;
			end else begin
				m_tready = !(idle_on && $urandom_range(99) < 20);
			end
		end
	end

	task automatic send_pixel(input logic [23:0] px);
		while (idle_on && $urandom_range(99) < 20) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = px;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic send_image(input int unsigned npix, input int mode);
		logic [23:0] px;
		for (int unsigned i = 0; i < npix; i++) begin
			case (mode)
				0: px = '0;
				1: px = '1;
				2: px = i[0] ? 24'hFFFFFF : 24'h000000;
				default: px = 24'($urandom);
			endcase
			send_pixel(px);
		end
		s_tvalid = 0;
	endtask

	// wait until every seam entry is back and the block has settled
	task automatic drain();
		s_tvalid = 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	initial begin
		int unsigned w, h;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 0;
		s_tdata = '0;
		idle_on = 0;
		hold_req = 0;
		pixels_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// dimensions below the floor act as 2x2
		write_reg(REG_WIDTH, 7'd0);
		write_reg(REG_HEIGHT, 7'd1);
		for (int m = 0; m < 4; m++) send_image(4, m);
		drain();
		// a register write in the middle of an image restarts the load
		send_pixel(24'hA5C33C);
		s_tvalid = 0;
		drain();
		write_reg(REG_WIDTH, 7'd3);
		send_image(6, 3);
		drain();
		// widest image, width above the ceiling
		write_reg(REG_WIDTH, 7'd127);
		write_reg(REG_HEIGHT, 7'd2);
		send_image(128, 3);
		drain();

		// tallest image, random idling from here on
		idle_on = 1;
		write_reg(REG_WIDTH, 7'd2);
		write_reg(REG_HEIGHT, 7'd64);
		send_image(128, 3);
		drain();

		// random small images, two back to back per setting; receiver holds off first
		hold_req = 1;
		while (pixels_sent < 285) begin
			w = $urandom_range(4, 2);
			h = $urandom_range(4, 2);
			write_reg(REG_WIDTH, 7'(w));
			write_reg(REG_HEIGHT, 7'(h));
			for (int k = 0; k < 2; k++) send_image(w * h, 3);
			drain();
		end

		repeat (100) @(negedge clk);
		if (fails == 0)
			$display("seam_carving_horizontal_seam_tb passed");
		else
			$display("seam_carving_horizontal_seam_tb failed");
		$finish;
	end
endmodule
